// ----- design/bmp_stream_decoder_defines.svh -----
// Assertion helpers for the decoder top level.
`ifndef BMP_STREAM_DECODER_DEFINES_SVH
`define BMP_STREAM_DECODER_DEFINES_SVH

// Checked only outside reset.
`define BMP_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every edge, reset included.
`define BMP_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/bmp_pkg.sv -----
package bmp_pkg;

   // input word kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   // result word kinds
   localparam logic OUT_VERDICT = 1'b0;
   localparam logic OUT_PIXEL   = 1'b1;

   // verdict status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_SHORT      = 3'd1;
   localparam logic [2:0] ST_SIGNATURE  = 3'd2;
   localparam logic [2:0] ST_DIMENSIONS = 3'd3;
   localparam logic [2:0] ST_DEPTH      = 3'd4;
   localparam logic [2:0] ST_TRUNCATED  = 3'd5;
   localparam logic [2:0] ST_LIMIT      = 3'd6;

   localparam logic [31:0] HEADER_BYTES = 32'd54;

   // byte positions inside the file header
   localparam logic [31:0] OFS_SIG0    = 32'd0;
   localparam logic [31:0] OFS_SIG1    = 32'd1;
   localparam logic [31:0] OFS_DATA    = 32'd10;
   localparam logic [31:0] OFS_WIDTH   = 32'd18;
   localparam logic [31:0] OFS_HEIGHT  = 32'd22;
   localparam logic [31:0] OFS_ABS     = 32'd26;
   localparam logic [31:0] OFS_PROD    = 32'd27;
   localparam logic [31:0] OFS_DEPTH   = 32'd28;
   localparam logic [31:0] OFS_VERDICT = 32'd29;
   localparam logic [31:0] OFS_PIXELS  = 32'd30;

   localparam logic [7:0]  CHAR_B       = 8'h42;
   localparam logic [7:0]  CHAR_M       = 8'h4D;
   localparam logic [15:0] DEPTH_24     = 16'd24;
   localparam logic [15:0] DEPTH_32     = 16'd32;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic        kind;
      logic [31:0] file_length;
      logic [7:0]  data_byte;
   } bmp_req_type;

   typedef struct packed {
      logic        out_kind;
      logic [2:0]  status;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [11:0] pixel_column;
      logic [11:0] pixel_row;
      logic        last_pixel;
   } bmp_rsp_type;

   // header parser to pixel walker; start, verdict, verdict_good and pix_byte are qualified by the advancing word
   typedef struct packed {
      logic start;
      logic verdict;
      logic verdict_good;
      logic pix_byte;
      logic depth32;
      logic flip;
   } bmp_hdr_ctl_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [11:0] column;
      logic [11:0] row;
      logic        last;
   } bmp_pix_type;

endpackage

// ----- design/bmp_hdr.sv -----
module bmp_hdr
   import bmp_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   localparam int CW = $clog2(MAX_WIDTH + 1),
   localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  bmp_req_type     req,
   output bmp_hdr_ctl_type ctl,
   output logic [2:0]      vd_status,
   output logic [12:0]     vd_width,
   output logic [12:0]     vd_height,
   output logic [CW-1:0]   width,
   output logic [RW-1:0]   height
);

   logic [31:0] byte_offset_ff, byte_offset_in;
   logic [31:0] file_size_ff, file_size_in;
   logic [31:0] data_start_ff, data_start_in;
   logic [31:0] raw_width_ff, raw_width_in;
   logic [31:0] raw_height_ff, raw_height_in;
   logic [31:0] abs_height_ff, abs_height_in;
   logic [63:0] product_ff, product_in;
   logic        trunc_ff, trunc_in;
   logic [7:0]  depth_lo_ff, depth_lo_in;
   logic        sig_ok_ff, sig_ok_in;

   logic [7:0]  b;
   logic        byte_ok;
   logic [64:0] need;
   logic [15:0] depth_full;
   logic [2:0]  judge;

   assign b          = req.data_byte;
   assign depth_full = {b, depth_lo_ff};
   assign need       = {33'd0, data_start_ff} + {1'b0, product_ff[61:0], 2'b00};
   assign byte_ok    = fire && (req.kind == KIND_BYTE) && (file_size_ff >= HEADER_BYTES)
                       && (byte_offset_ff < file_size_ff);

   // checks in priority order; truncation was settled one byte earlier
   always_comb begin
      if (!sig_ok_ff) begin
         judge = ST_SIGNATURE;
      end else if (raw_width_ff[31] || (raw_width_ff == 32'd0) || (raw_height_ff == 32'd0)) begin
         judge = ST_DIMENSIONS;
      end else if ((depth_full != DEPTH_24) && (depth_full != DEPTH_32)) begin
         judge = ST_DEPTH;
      end else if (trunc_ff) begin
         judge = ST_TRUNCATED;
      end else if ((raw_width_ff > 32'(MAX_WIDTH)) || (abs_height_ff > 32'(MAX_HEIGHT))
                   || (data_start_ff < HEADER_BYTES)) begin
         judge = ST_LIMIT;
      end else begin
         judge = ST_OK;
      end
   end

   always_comb begin
      byte_offset_in = byte_offset_ff;
      file_size_in   = file_size_ff;
      data_start_in  = data_start_ff;
      raw_width_in   = raw_width_ff;
      raw_height_in  = raw_height_ff;
      abs_height_in  = abs_height_ff;
      product_in     = product_ff;
      trunc_in       = trunc_ff;
      depth_lo_in    = depth_lo_ff;
      sig_ok_in      = sig_ok_ff;
      ctl            = '0;
      vd_status      = ST_OK;
      vd_width       = '0;
      vd_height      = '0;

      ctl.depth32 = (depth_full == DEPTH_32);
      ctl.flip    = !raw_height_ff[31];

      if (fire && (req.kind == KIND_START)) begin
         ctl.start      = 1'b1;
         byte_offset_in = '0;
         file_size_in   = req.file_length;
         data_start_in  = '0;
         raw_width_in   = '0;
         raw_height_in  = '0;
         abs_height_in  = '0;
         product_in     = '0;
         trunc_in       = 1'b0;
         depth_lo_in    = '0;
         sig_ok_in      = 1'b0;
         if (req.file_length < HEADER_BYTES) begin
            ctl.verdict = 1'b1;
            vd_status   = ST_SHORT;
         end
      end else if (byte_ok) begin
         byte_offset_in = byte_offset_ff + 32'd1;
         case (byte_offset_ff)
            OFS_SIG0:            sig_ok_in            = (b == CHAR_B);
            OFS_SIG1:            sig_ok_in            = sig_ok_ff && (b == CHAR_M);
            OFS_DATA:            data_start_in[7:0]   = b;
            OFS_DATA + 32'd1:    data_start_in[15:8]  = b;
            OFS_DATA + 32'd2:    data_start_in[23:16] = b;
            OFS_DATA + 32'd3:    data_start_in[31:24] = b;
            OFS_WIDTH:           raw_width_in[7:0]    = b;
            OFS_WIDTH + 32'd1:   raw_width_in[15:8]   = b;
            OFS_WIDTH + 32'd2:   raw_width_in[23:16]  = b;
            OFS_WIDTH + 32'd3:   raw_width_in[31:24]  = b;
            OFS_HEIGHT:          raw_height_in[7:0]   = b;
            OFS_HEIGHT + 32'd1:  raw_height_in[15:8]  = b;
            OFS_HEIGHT + 32'd2:  raw_height_in[23:16] = b;
            OFS_HEIGHT + 32'd3:  raw_height_in[31:24] = b;
            // height is complete: take its magnitude, then multiply, then compare
            OFS_ABS: begin
               abs_height_in = raw_height_ff[31] ? (32'd0 - raw_height_ff) : raw_height_ff;
            end
            OFS_PROD: product_in = {32'd0, raw_width_ff} * {32'd0, abs_height_ff};
            OFS_DEPTH: begin
               depth_lo_in = b;
               trunc_in    = need > {33'd0, file_size_ff};
            end
            OFS_VERDICT: begin
               ctl.verdict      = 1'b1;
               ctl.verdict_good = (judge == ST_OK);
               vd_status        = judge;
               if (judge == ST_OK) begin
                  vd_width  = raw_width_ff[12:0];
                  vd_height = abs_height_ff[12:0];
               end
            end
            default: begin
            end
         endcase
         ctl.pix_byte = (byte_offset_ff >= OFS_PIXELS) && (byte_offset_ff >= data_start_ff);
      end
   end

   assign width  = raw_width_ff[CW-1:0];
   assign height = abs_height_ff[RW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff <= '0;
         file_size_ff   <= '0;
         data_start_ff  <= '0;
         raw_width_ff   <= '0;
         raw_height_ff  <= '0;
         abs_height_ff  <= '0;
         product_ff     <= '0;
         trunc_ff       <= 1'b0;
         depth_lo_ff    <= '0;
         sig_ok_ff      <= 1'b0;
      end else begin
         byte_offset_ff <= byte_offset_in;
         file_size_ff   <= file_size_in;
         data_start_ff  <= data_start_in;
         raw_width_ff   <= raw_width_in;
         raw_height_ff  <= raw_height_in;
         abs_height_ff  <= abs_height_in;
         product_ff     <= product_in;
         trunc_ff       <= trunc_in;
         depth_lo_ff    <= depth_lo_in;
         sig_ok_ff      <= sig_ok_in;
      end
   end

endmodule

// ----- design/bmp_pix.sv -----
module bmp_pix
   import bmp_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   localparam int CW = $clog2(MAX_WIDTH + 1),
   localparam int RW = $clog2(MAX_HEIGHT + 1),
   localparam int UW = $clog2(MAX_WIDTH * 4 + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  bmp_hdr_ctl_type ctl,
   input  logic [7:0]      data_byte,
   input  logic [CW-1:0]   width,
   input  logic [RW-1:0]   height,
   output logic            pix_emit,
   output bmp_pix_type     pix
);

   logic          active_ff, active_in;
   logic          depth32_ff, depth32_in;
   logic          flip_ff, flip_in;
   logic [CW-1:0] w_ff, w_in;
   logic [RW-1:0] h_ff, h_in;
   logic [UW-1:0] used_ff, used_in;
   logic [UW-1:0] row_size_ff, row_size_in;
   logic [UW-1:0] row_byte_ff, row_byte_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [1:0]    bip_ff, bip_in;
   logic [23:0]   pbytes_ff, pbytes_in;

   logic [UW-1:0] wx;
   logic [UW-1:0] used_calc;
   logic [UW:0]   pad_sum;
   logic [UW-1:0] row_calc;
   logic [UW-1:0] row_byte_inc;
   logic [RW-1:0] row_inc;
   logic [CW-1:0] col_inc;
   logic [RW-1:0] dest_row;
   logic [1:0]    last_bip;

   assign wx           = UW'(width);
   assign used_calc    = ctl.depth32 ? (wx << 2) : ((wx << 1) + wx);
   assign pad_sum      = {1'b0, used_calc} + (UW+1)'(3);
   assign row_calc     = UW'({pad_sum[UW:2], 2'b00});
   assign row_byte_inc = row_byte_ff + UW'(1);
   assign row_inc      = row_ff + RW'(1);
   assign col_inc      = col_ff + CW'(1);
   assign dest_row     = flip_ff ? (h_ff - RW'(1) - row_ff) : row_ff;
   assign last_bip     = depth32_ff ? 2'd3 : 2'd2;

   always_comb begin
      active_in   = active_ff;
      depth32_in  = depth32_ff;
      flip_in     = flip_ff;
      w_in        = w_ff;
      h_in        = h_ff;
      used_in     = used_ff;
      row_size_in = row_size_ff;
      row_byte_in = row_byte_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      bip_in      = bip_ff;
      pbytes_in   = pbytes_ff;
      pix_emit    = 1'b0;

      pix.red    = depth32_ff ? pbytes_ff[23:16] : data_byte;
      pix.green  = pbytes_ff[15:8];
      pix.blue   = pbytes_ff[7:0];
      pix.alpha  = depth32_ff ? data_byte : ALPHA_OPAQUE;
      pix.column = 12'(col_ff);
      pix.row    = 12'(dest_row);
      pix.last   = (row_inc == h_ff) && (col_inc == w_ff);

      if (ctl.start) begin
         active_in   = 1'b0;
         row_byte_in = '0;
         col_in      = '0;
         row_in      = '0;
         bip_in      = '0;
         pbytes_in   = '0;
      end else if (ctl.verdict_good) begin
         active_in   = 1'b1;
         depth32_in  = ctl.depth32;
         flip_in     = ctl.flip;
         w_in        = width;
         h_in        = height;
         used_in     = used_calc;
         row_size_in = row_calc;
      end else if (ctl.pix_byte && active_ff) begin
         if (row_ff >= h_ff) begin
            active_in = 1'b0;
         end else begin
            if (row_byte_ff < used_ff) begin
               if (bip_ff == last_bip) begin
                  pix_emit  = 1'b1;
                  col_in    = col_inc;
                  pbytes_in = '0;
                  bip_in    = '0;
               end else begin
                  case (bip_ff)
                     2'd0:    pbytes_in[7:0]   = data_byte;
                     2'd1:    pbytes_in[15:8]  = data_byte;
                     default: pbytes_in[23:16] = data_byte;
                  endcase
                  bip_in = bip_ff + 2'd1;
               end
            end
            // end of row, padding included
            if (row_byte_inc >= row_size_ff) begin
               row_byte_in = '0;
               col_in      = '0;
               row_in      = row_inc;
               if (row_inc >= h_ff) begin
                  active_in = 1'b0;
               end
            end else begin
               row_byte_in = row_byte_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         depth32_ff  <= 1'b0;
         flip_ff     <= 1'b0;
         w_ff        <= '0;
         h_ff        <= '0;
         used_ff     <= '0;
         row_size_ff <= '0;
         row_byte_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         bip_ff      <= '0;
         pbytes_ff   <= '0;
      end else begin
         active_ff   <= active_in;
         depth32_ff  <= depth32_in;
         flip_ff     <= flip_in;
         w_ff        <= w_in;
         h_ff        <= h_in;
         used_ff     <= used_in;
         row_size_ff <= row_size_in;
         row_byte_ff <= row_byte_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         bip_ff      <= bip_in;
         pbytes_ff   <= pbytes_in;
      end
   end

endmodule

// ----- design/bmp_stream_decoder.sv -----
//  channel  direction  handshake             word
//  req      in         req_valid/req_stall   bmp_req_type: start with length, or one file byte
//  rsp      out        rsp_valid/rsp_stall   bmp_rsp_type: header verdict or one RGBA pixel
//
//  One word per cycle sustained while the result is not stalled; an accepted word is
//  held in the input register, decoded, and its result is presented from the result
//  register, the two registers around the decode logic.
//  Reset is synchronous and clears all counters and the valid bits of both registers.
//  A stalled result holds and lets one more word into the input register; further
//  words then wait until the result is taken.
`include "bmp_stream_decoder_defines.svh"

module bmp_stream_decoder
   import bmp_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  bmp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bmp_rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);

   logic            in_valid_ff, in_valid_in;
   bmp_req_type     in_data_ff, in_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   bmp_rsp_type     rsp_data_ff, rsp_data_in;

   logic            advance;
   logic            fire;
   logic            req_accept;
   bmp_hdr_ctl_type hdr_ctl;
   logic [2:0]      vd_status;
   logic [12:0]     vd_width;
   logic [12:0]     vd_height;
   logic [CW-1:0]   geo_width;
   logic [RW-1:0]   geo_height;
   logic            pix_emit;
   bmp_pix_type     pix;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && advance;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   bmp_hdr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_hdr (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .req       (in_data_ff),
      .ctl       (hdr_ctl),
      .vd_status (vd_status),
      .vd_width  (vd_width),
      .vd_height (vd_height),
      .width     (geo_width),
      .height    (geo_height)
   );

   bmp_pix #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pix (
      .clock     (clock),
      .reset     (reset),
      .ctl       (hdr_ctl),
      .data_byte (in_data_ff.data_byte),
      .width     (geo_width),
      .height    (geo_height),
      .pix_emit  (pix_emit),
      .pix       (pix)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = fire && (hdr_ctl.verdict || pix_emit);
         rsp_data_in  = '0;
         if (hdr_ctl.verdict) begin
            rsp_data_in.out_kind     = OUT_VERDICT;
            rsp_data_in.status       = vd_status;
            rsp_data_in.image_width  = vd_width;
            rsp_data_in.image_height = vd_height;
         end else begin
            rsp_data_in.out_kind     = OUT_PIXEL;
            rsp_data_in.status       = ST_OK;
            rsp_data_in.red          = pix.red;
            rsp_data_in.green        = pix.green;
            rsp_data_in.blue         = pix.blue;
            rsp_data_in.alpha        = pix.alpha;
            rsp_data_in.pixel_column = pix.column;
            rsp_data_in.pixel_row    = pix.row;
            rsp_data_in.last_pixel   = pix.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BMP_CHECK(a_in_hold, in_valid_ff && !fire |=> in_valid_ff && $stable(in_data_ff), "held input word lost")
   `BMP_CHECK(a_one_source, !(hdr_ctl.verdict && pix_emit), "verdict and pixel in one word")
   `BMP_CHECK(a_emit_on_fire, (hdr_ctl.verdict || pix_emit) |-> fire, "result from a word not advancing")
   `BMP_CHECK_ALWAYS(a_reset_empty, reset |=> !rsp_valid_ff && !in_valid_ff, "registers not empty after reset")

endmodule
